>>> sv/sig_pkg.sv
// ----------------------------------------------------------------------------
// sig_pkg
// Shared types and constants of the sphere index generator.
// ----------------------------------------------------------------------------
package sig_pkg;

  localparam int IDX_W     = 12;  // vertex index width
  localparam int CFG_W     = 7;   // configuration register width
  localparam int CFG_IDX_W = 1;   // configuration register index width

  localparam logic [CFG_IDX_W-1:0] REG_LAT_DIV  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_DIV = 1'd1;

  localparam logic [CFG_W-1:0] LAT_DIV_RESET  = 7'd20;
  localparam logic [CFG_W-1:0] LONG_DIV_RESET = 7'd40;

  typedef struct packed {
    logic [IDX_W-1:0] tri1_a;
    logic [IDX_W-1:0] tri1_b;
    logic [IDX_W-1:0] tri1_c;
    logic [IDX_W-1:0] tri2_a;
    logic [IDX_W-1:0] tri2_b;
    logic [IDX_W-1:0] tri2_c;
    logic             mesh_done;
  } sig_result_t;

endpackage

>>> sv/sphere_index_generator.sv
// ----------------------------------------------------------------------------
// sphere_index_generator
// Triangle-list index stream of a latitude-longitude sphere, one cell a beat.
// ----------------------------------------------------------------------------
// Each accepted input beat yields one cell: two triangles (six 12-bit vertex
// indices). Body bands come first, column by column, then long_divisions cap
// cells pairing a north-pole and a south-pole triangle; mesh_done marks the
// final cap cell, after which the walk wraps. restart returns the first cell.
// Throughput is one cell per clock while in_stall is low: the walk counters
// and running row base update in the cycle a beat is accepted, and the
// result is registered in the output register. A one-entry skid buffer
// keeps input accepted for one more beat while the output is stalled.
// Writing either register (only while idle) restarts the walk; register
// values are clamped to 2..MAX_LAT_DIV and 3..MAX_LONG_DIV.
// ----------------------------------------------------------------------------
module sphere_index_generator #(
  parameter int MAX_LAT_DIV  = 64,
  parameter int MAX_LONG_DIV = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sig_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sig_pkg::IDX_W-1:0]     tri1_a,
  output logic [sig_pkg::IDX_W-1:0]     tri1_b,
  output logic [sig_pkg::IDX_W-1:0]     tri1_c,
  output logic [sig_pkg::IDX_W-1:0]     tri2_a,
  output logic [sig_pkg::IDX_W-1:0]     tri2_b,
  output logic [sig_pkg::IDX_W-1:0]     tri2_c,
  output logic                          mesh_done
);
  import sig_pkg::*;

  logic        accept;
  logic        full;
  sig_result_t walk_out;
  sig_result_t held;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  sig_walk #(
    .MAX_LAT_DIV  (MAX_LAT_DIV),
    .MAX_LONG_DIV (MAX_LONG_DIV)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .restart   (restart),
    .result    (walk_out)
  );

  sig_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (walk_out),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (held)
  );

  assign tri1_a    = held.tri1_a;
  assign tri1_b    = held.tri1_b;
  assign tri1_c    = held.tri1_c;
  assign tri2_a    = held.tri2_a;
  assign tri2_b    = held.tri2_b;
  assign tri2_c    = held.tri2_c;
  assign mesh_done = held.mesh_done;

endmodule

>>> sv/sig_walk.sv
// ----------------------------------------------------------------------------
// sig_walk
// Cell walk state and index arithmetic: one cell per accepted beat.
// ----------------------------------------------------------------------------
module sig_walk #(
  parameter int MAX_LAT_DIV  = 64,
  parameter int MAX_LONG_DIV = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sig_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sig_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               step,
  input  logic                               restart,
  output sig_pkg::sig_result_t               result
);
  import sig_pkg::*;

  localparam int BW  = (MAX_LAT_DIV  > 2) ? $clog2(MAX_LAT_DIV)  : 1;
  localparam int CW  = $clog2(MAX_LONG_DIV);
  localparam int LW  = $clog2(MAX_LAT_DIV + 1);
  localparam int LNW = $clog2(MAX_LONG_DIV + 1);

  logic [CFG_W-1:0] lat_divisions;
  logic [CFG_W-1:0] long_divisions;

  logic [BW-1:0]    band_index;
  logic [CW-1:0]    column_index;
  logic             in_cap_cells;
  logic [IDX_W-1:0] band_row_base;

  logic [BW-1:0]    band_index_next;
  logic [CW-1:0]    column_index_next;
  logic             in_cap_cells_next;
  logic [IDX_W-1:0] band_row_base_next;

  logic [LW-1:0]    lat;
  logic [LNW-1:0]   lng;
  logic [LW-1:0]    bands;
  logic [BW-1:0]    band;
  logic [CW-1:0]    col;
  logic [CW-1:0]    prev;
  logic [IDX_W-1:0] base;
  logic [IDX_W-1:0] nxt;
  logic             cap;
  logic             last_col;
  logic             cfg_hit;

  // saturate the registers to the supported range
  always_comb begin
    if (32'(lat_divisions) < 32'd2) begin
      lat = LW'(2);
    end else if (32'(lat_divisions) > 32'(MAX_LAT_DIV)) begin
      lat = LW'(MAX_LAT_DIV);
    end else begin
      lat = LW'(lat_divisions);
    end
    if (32'(long_divisions) < 32'd3) begin
      lng = LNW'(3);
    end else if (32'(long_divisions) > 32'(MAX_LONG_DIV)) begin
      lng = LNW'(MAX_LONG_DIV);
    end else begin
      lng = LNW'(long_divisions);
    end
  end

  assign bands = lat - LW'(2);

  always_comb begin
    // restart takes effect before the cell is formed
    band = restart ? '0 : band_index;
    col  = restart ? '0 : column_index;
    base = restart ? '0 : band_row_base;
    cap  = (restart ? 1'b0 : in_cap_cells) || (LW'(band) >= bands);

    prev     = (col == '0) ? CW'(lng - LNW'(1)) : col - CW'(1);
    nxt      = base + IDX_W'(lng);
    last_col = (LNW'(col) + LNW'(1)) >= lng;

    band_index_next    = band;
    column_index_next  = col + CW'(1);
    in_cap_cells_next  = cap;
    band_row_base_next = base;
    result.mesh_done   = 1'b0;

    if (!cap) begin
      result.tri1_a = base + IDX_W'(prev);
      result.tri1_b = nxt + IDX_W'(prev);
      result.tri1_c = base + IDX_W'(col);
      result.tri2_a = base + IDX_W'(col);
      result.tri2_b = nxt + IDX_W'(prev);
      result.tri2_c = nxt + IDX_W'(col);
      if (last_col) begin
        column_index_next  = '0;
        band_index_next    = band + BW'(1);
        band_row_base_next = nxt;
      end
    end else begin
      // caps: base holds the last body ring, nxt is the north pole
      result.tri1_a = IDX_W'(prev);
      result.tri1_b = IDX_W'(col);
      result.tri1_c = nxt;
      result.tri2_a = base + IDX_W'(col);
      result.tri2_b = base + IDX_W'(prev);
      result.tri2_c = nxt + IDX_W'(1);
      if (last_col) begin
        result.mesh_done   = 1'b1;
        band_index_next    = '0;
        column_index_next  = '0;
        in_cap_cells_next  = 1'b0;
        band_row_base_next = '0;
      end
    end
  end

  assign cfg_hit = cfg_we && ((cfg_index == REG_LAT_DIV) || (cfg_index == REG_LONG_DIV));

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_divisions  <= LAT_DIV_RESET;
      long_divisions <= LONG_DIV_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_LAT_DIV) begin
        lat_divisions <= cfg_data;
      end
      if (cfg_index == REG_LONG_DIV) begin
        long_divisions <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      band_index    <= '0;
      column_index  <= '0;
      in_cap_cells  <= 1'b0;
      band_row_base <= '0;
    end else if (step) begin
      band_index    <= band_index_next;
      column_index  <= column_index_next;
      in_cap_cells  <= in_cap_cells_next;
      band_row_base <= band_row_base_next;
    end
  end

endmodule

>>> sv/sig_skid.sv
// ----------------------------------------------------------------------------
// sig_skid
// Output register with one skid entry, so the walk can take one more step
// while a finished cell waits.
// ----------------------------------------------------------------------------
module sig_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sig_pkg::sig_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sig_pkg::sig_result_t out_data
);
  import sig_pkg::*;

  logic        skid_valid;
  sig_result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule
